FILE: hdl/plg_pkg.sv
// Shared types and constants for the pixel tone curve pipeline.
// Used by plg_expm1 and pixel_log_exp_gamma_curve; depends on nothing.
`default_nettype none

package plg_pkg;

  // default sample width
  localparam int PIXEL_BITS_DEF = 16;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CURVE_MODE = 1'b0,
    REG_STRENGTH   = 1'b1
  } cfg_reg_t;

  // fixed point, 32 fraction bits
  localparam logic [32:0] Q_ONE = 33'h1_0000_0000;
  localparam logic [31:0] Q_LN2 = 32'd2977044472;

  // series lengths (terms beyond these are always zero)
  localparam int EXP_TERMS = 16;
  localparam int LN_TERMS  = 14;

  // exponent argument (up to 16.0) and e^t - 1 result widths
  localparam int T_W   = 37;
  localparam int EXP_W = 58;

endpackage

`default_nettype wire

FILE: hdl/pixel_log_exp_gamma_curve.sv
// Top level of the pixel tone curve: log/exp gamma or inversion per sample.
// Depends on plg_pkg, plg_expm1 and plg_div.
//
//   channel   | dir | signals                            | payload
//   ----------+-----+------------------------------------+-------------------------
//   s_axis    | in  | s_axis_tvalid/tready/tdata         | tdata: pixel_in [PB-1:0]
//   m_axis    | out | m_axis_tvalid/tready/tdata         | tdata: pixel_out [PB-1:0]
//   cfg       | in  | cfg_we, cfg_index, cfg_data        | 0 curve_mode, 1 strength
//
// One request per cycle while m_axis does not stall; the pipeline is built from
// the two e^x-1 series, the 32-step divider for the log argument, the log series
// and the PIXEL_BITS-step output divider.
// A stall on m_axis freezes the whole pipeline; s_axis_tready falls with it.
// rst (synchronous) clears the valid bits and the configuration registers.
`default_nettype none

module pixel_log_exp_gamma_curve #(
  parameter int PIXEL_BITS = plg_pkg::PIXEL_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((PIXEL_BITS+7)/8)*8-1:0]       s_axis_tdata,   // pixel_in
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [((PIXEL_BITS+7)/8)*8-1:0]       m_axis_tdata,   // pixel_out
  input  logic                                  cfg_we,
  input  logic [plg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [plg_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import plg_pkg::*;

  localparam int PB     = PIXEL_BITS;
  localparam int TD_W   = ((PB + 7) / 8) * 8;
  localparam int MAG_W  = 17;
  localparam int PRD_W  = MAG_W + PB;
  localparam int XQ_W   = 33;
  localparam int V_W    = 60;
  localparam int LK_W   = 5;
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 34;
  localparam int U_W    = 32;
  localparam int SUM_W  = 33;
  localparam int L_W    = 38;
  localparam int DVS_W  = 40;
  localparam int DVD_W  = DVS_W + PB;
  localparam int NSH_W  = 5;

  localparam logic [63:0]   M64    = (64'd1 << PB) - 64'd1;
  localparam logic [63:0]   HALF_M = M64 >> 1;
  localparam logic [PB-1:0] PIX_M  = '1;

  // stage indexes
  localparam int I2      = 3;
  localparam int IE      = I2 + 2 * EXP_TERMS + 3;
  localparam int IU      = IE + 4 + U_W;
  localparam int IL      = IU + 3 + LN_TERMS;
  localparam int IQ      = IL + 2 + PB;
  localparam int LAT_OUT = IQ + 1;

  // configuration registers
  logic              curve_mode;
  logic [MAG_W-1:0]  strength;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode <= 1'b0;
      strength   <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_CURVE_MODE: curve_mode <= cfg_data[0];
        REG_STRENGTH:   strength   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic             s_neg;
  logic             s_zero;
  logic [MAG_W-1:0] mag;

  assign s_neg  = strength[MAG_W-1];
  assign s_zero = (strength == '0);
  assign mag    = s_neg ? MAG_W'(18'h20000 - {1'b0, strength}) : strength;

  // pipeline control
  logic [LAT_OUT:0] vld;
  logic             en;

  assign en            = !vld[LAT_OUT] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[LAT_OUT];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT_OUT-1:0], s_axis_tvalid};
  end

  // pixel travels to the output stage
  logic [PB-1:0] pix [0:IQ];

  always_ff @(posedge clk) begin
    if (en) pix[0] <= s_axis_tdata[PB-1:0];
  end

  for (genvar j = 1; j <= IQ; j++) begin : g_pix
    always_ff @(posedge clk) begin
      if (en) pix[j] <= pix[j-1];
    end
  end

  // scaled argument t = a*x and x in fixed point; n/M is estimated from the
  // sum of n >> k*PB (low by at most one), then corrected a stage later
  logic [PRD_W-1:0] prod1;
  logic [63:0]      tn_c, xn_c;
  logic [63:0]      tn_a, tq_a, xn_a, xq_a;
  logic [63:0]      tr_c, xr_c;
  logic [T_W-1:0]   t2;
  logic [XQ_W-1:0]  xq_p [I2:IE];

  function automatic logic [63:0] div_m_est(input logic [63:0] n);
    logic [63:0] acc;
    acc = '0;
    for (int k = 0; k * PB < 64; k++) acc = acc + (n >> (k * PB));
    return acc >> PB;
  endfunction

  assign tn_c = (64'(prod1) << 20) + HALF_M;
  assign xn_c = (64'(pix[1]) << 32) + HALF_M;
  assign tr_c = tn_a - ((tq_a << PB) - tq_a);
  assign xr_c = xn_a - ((xq_a << PB) - xq_a);

  always_ff @(posedge clk) begin
    if (en) begin
      prod1    <= PRD_W'(mag) * PRD_W'(pix[0]);
      tn_a     <= tn_c;
      tq_a     <= div_m_est(tn_c);
      xn_a     <= xn_c;
      xq_a     <= div_m_est(xn_c);
      t2       <= T_W'(tq_a + 64'(tr_c >= M64));
      xq_p[I2] <= XQ_W'(xq_a + 64'(xr_c >= M64));
    end
  end

  for (genvar j = I2 + 1; j <= IE; j++) begin : g_xq
    always_ff @(posedge clk) begin
      if (en) xq_p[j] <= xq_p[j-1];
    end
  end

  // denominator e^|s|-1 and numerator e^(|s|x)-1
  logic [EXP_W-1:0] d_e;
  logic [EXP_W-1:0] n_e;

  plg_expm1 #(.NT(EXP_TERMS)) u_exp_d (
    .clk (clk),
    .en  (en),
    .t   (T_W'(mag) << 20),
    .e   (d_e)
  );

  plg_expm1 #(.NT(EXP_TERMS)) u_exp_n (
    .clk (clk),
    .en  (en),
    .t   (t2),
    .e   (n_e)
  );

  // ---------------- positive strength: ln(1 + x*(e^s-1)) ----------------
  logic [58:0]      ph;
  logic [64:0]      pl;
  logic [V_W-1:0]   v2;
  logic [V_W-1:0]   v3;
  logic [LK_W-1:0]  lnk_c;
  logic [32:0]      m_c;
  logic [NUM_W-1:0] num4;
  logic [DEN_W-1:0] den4;
  logic [LK_W-1:0]  lnk_p [IE+3:IL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      ph <= 59'(d_e[EXP_W-1:32]) * 59'(xq_p[IE]);
      pl <= 65'(d_e[31:0]) * 65'(xq_p[IE]);
      v2 <= V_W'(64'(Q_ONE) + 64'(ph) + 64'((pl + 65'h8000_0000) >> 32));
    end
  end

  // normalize so the mantissa lies in [1, 2)
  always_comb begin
    lnk_c = '0;
    for (int b = 33; b < V_W; b++) begin
      if (v2[b]) lnk_c = LK_W'(b - 32);
    end
  end

  assign m_c = 33'(v3 >> lnk_p[IE+3]);

  always_ff @(posedge clk) begin
    if (en) begin
      v3          <= v2;
      lnk_p[IE+3] <= lnk_c;
      num4        <= {m_c[31:0], 32'd0};
      den4        <= DEN_W'(m_c) + DEN_W'(Q_ONE);
    end
  end

  for (genvar j = IE + 4; j <= IL - 1; j++) begin : g_lnk
    always_ff @(posedge clk) begin
      if (en) lnk_p[j] <= lnk_p[j-1];
    end
  end

  // u = (m-1)/(m+1)
  logic [U_W-1:0] u_q;

  plg_div #(.NW(NUM_W), .DW(DEN_W), .QW(U_W)) u_div_ln (
    .clk (clk),
    .en  (en),
    .num (num4),
    .den (den4),
    .quo (u_q)
  );

  logic [63:0]      usq;
  logic [U_W-1:0]   u1;
  logic [U_W-1:0]   term_l [0:LN_TERMS];
  logic [U_W-1:0]   u2_l   [0:LN_TERMS];
  logic [SUM_W-1:0] sum_l  [0:LN_TERMS];

  always_ff @(posedge clk) begin
    if (en) begin
      usq       <= 64'(u_q) * 64'(u_q);
      u1        <= u_q;
      u2_l[0]   <= U_W'((usq + 64'h8000_0000) >> 32);
      term_l[0] <= u1;
      sum_l[0]  <= '0;
    end
  end

  // atanh series: sum of u^(2s-1)/(2s-1), the divide by reciprocal multiply
  for (genvar s = 1; s <= LN_TERMS; s++) begin : g_ln
    localparam int          DL     = $clog2(2 * s - 1);
    localparam logic [32:0] DMAGIC = 33'((64'd1 << (32 + DL)) / 64'(2 * s - 1) + 64'd1);
    always_ff @(posedge clk) begin
      if (en) begin
        sum_l[s]  <= sum_l[s-1] +
                     SUM_W'((65'(term_l[s-1]) * 65'(DMAGIC)) >> (32 + DL));
        term_l[s] <= U_W'((64'(term_l[s-1]) * 64'(u2_l[s-1]) + 64'h8000_0000) >> 32);
        u2_l[s]   <= u2_l[s-1];
      end
    end
  end

  logic [L_W-1:0]   l_r;
  logic [DVD_W-1:0] pdv;

  always_ff @(posedge clk) begin
    if (en) begin
      l_r <= L_W'(lnk_p[IL-1]) * L_W'(Q_LN2) + L_W'({sum_l[LN_TERMS], 1'b0});
      pdv <= DVD_W'(l_r) * DVD_W'(M64);
    end
  end

  // ---------------- negative strength: ratio of two exponentials ----------
  logic [NSH_W-1:0] nsh_c;
  logic [NSH_W-1:0] nsh1;
  logic [EXP_W-1:0] dn1, nn1, dn2, nn2;
  logic             nsat_p [IE+3:IL+1];
  logic [DVD_W-1:0] ndv_p  [IE+3:IL+1];
  logic [DVS_W-1:0] ndn_p  [IE+3:IL+1];

  // shift both until the denominator is below 2^40
  always_comb begin
    nsh_c = '0;
    for (int b = DVS_W; b < EXP_W; b++) begin
      if (d_e[b]) nsh_c = NSH_W'(b - DVS_W + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn1            <= d_e;
      nn1            <= n_e;
      nsh1           <= nsh_c;
      dn2            <= dn1 >> nsh1;
      nn2            <= nn1 >> nsh1;
      nsat_p[IE+3]   <= (dn2 == '0) || (nn2 >= dn2);
      ndv_p[IE+3]    <= DVD_W'(nn2[DVS_W-1:0]) * DVD_W'(M64);
      ndn_p[IE+3]    <= dn2[DVS_W-1:0];
    end
  end

  for (genvar j = IE + 4; j <= IL + 1; j++) begin : g_neg
    always_ff @(posedge clk) begin
      if (en) begin
        nsat_p[j] <= nsat_p[j-1];
        ndv_p[j]  <= ndv_p[j-1];
        ndn_p[j]  <= ndn_p[j-1];
      end
    end
  end

  // ---------------- shared output divider ----------------
  logic [DVS_W-1:0] pos_den;
  logic [DVD_W-1:0] dv_r;
  logic [DVS_W-1:0] ds_r;
  logic             sat_p [IL+2:IQ];
  logic [PB-1:0]    q_o;

  assign pos_den = DVS_W'(strength) << 20;

  always_ff @(posedge clk) begin
    if (en) begin
      if (s_neg) begin
        dv_r        <= ndv_p[IL+1];
        ds_r        <= ndn_p[IL+1];
        sat_p[IL+2] <= nsat_p[IL+1];
      end else begin
        dv_r        <= pdv;
        ds_r        <= pos_den;
        sat_p[IL+2] <= pdv >= (DVD_W'(pos_den) << PB);
      end
    end
  end

  for (genvar j = IL + 3; j <= IQ; j++) begin : g_sat
    always_ff @(posedge clk) begin
      if (en) sat_p[j] <= sat_p[j-1];
    end
  end

  plg_div #(.NW(DVD_W), .DW(DVS_W), .QW(PB)) u_div_out (
    .clk (clk),
    .en  (en),
    .num (dv_r),
    .den (ds_r),
    .quo (q_o)
  );

  // output register
  logic [PB-1:0] res_c;

  always_comb begin
    if (curve_mode)       res_c = pix[IQ] ^ PIX_M;
    else if (s_zero)      res_c = pix[IQ];
    else if (sat_p[IQ])   res_c = PIX_M;
    else                  res_c = q_o;
  end

  always_ff @(posedge clk) begin
    if (en) m_axis_tdata <= TD_W'(res_c);
  end

endmodule

`default_nettype wire

FILE: hdl/plg_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; the caller guarantees the quotient fits in QW bits.
`default_nettype none

module plg_div #(
  parameter int NW = 64,
  parameter int DW = 34,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_s [0:QW];
  logic [DW-1:0] den_s [0:QW];
  logic [QW-1:0] quo_s [0:QW];

  assign rem_s[0] = num;
  assign den_s[0] = den;
  assign quo_s[0] = '0;

  // stage j decides quotient bit QW-j
  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int SH = QW - j;
    logic [CW-1:0] trial;
    logic          ge;
    assign trial = CW'(den_s[j-1]) << SH;
    assign ge    = CW'(rem_s[j-1]) >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[j] <= ge ? NW'(CW'(rem_s[j-1]) - trial) : rem_s[j-1];
        den_s[j] <= den_s[j-1];
        quo_s[j] <= {quo_s[j-1][QW-2:0], ge};
      end
    end
  end

  assign quo = quo_s[QW];

endmodule

`default_nettype wire

FILE: hdl/plg_expm1.sv
// Pipelined e^t - 1 in fixed point with 32 fraction bits (t up to 16.0).
// Range reduction by ln 2, Taylor series one term per stage pair; uses plg_pkg.
`default_nettype none

module plg_expm1 #(
  parameter int NT = plg_pkg::EXP_TERMS
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [plg_pkg::T_W-1:0]  t,
  output logic [plg_pkg::EXP_W-1:0] e
);
  import plg_pkg::*;

  localparam int KMAX = 24;
  localparam int K_W  = 5;
  localparam int NP   = 2 * NT;

  logic [T_W-1:0] t1;
  logic [K_W-1:0] k1;
  logic [K_W-1:0] k_c;
  logic [31:0]    r_c;

  logic [31:0]    r_s    [0:NP];
  logic [K_W-1:0] k_s    [0:NP];
  logic [31:0]    term_s [0:NP];
  logic [34:0]    sum_s  [0:NP];

  // k = floor(t / ln2) by thermometer compare
  always_comb begin
    k_c = '0;
    for (int j = 1; j <= KMAX; j++) begin
      if (64'(t) >= 64'(j) * 64'(Q_LN2)) k_c = K_W'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1 <= t;
      k1 <= k_c;
    end
  end

  // remainder r = t - k*ln2, below ln2
  assign r_c = 32'(t1 - T_W'(k1) * T_W'(Q_LN2));

  always_ff @(posedge clk) begin
    if (en) begin
      r_s[0]    <= r_c;
      k_s[0]    <= k1;
      term_s[0] <= r_c;
      sum_s[0]  <= '0;
    end
  end

  // term i: accumulate, multiply by r (rounded), then divide by i+1
  // (reciprocal multiply, exact for every 32-bit term)
  for (genvar i = 1; i <= NT; i++) begin : g_term
    localparam int          PM    = 2 * i - 1;
    localparam int          PD    = 2 * i;
    localparam int          DL    = $clog2(i + 1);
    localparam logic [32:0] MAGIC = 33'((64'd1 << (32 + DL)) / 64'(i + 1) + 64'd1);
    always_ff @(posedge clk) begin
      if (en) begin
        r_s[PM]    <= r_s[PM-1];
        k_s[PM]    <= k_s[PM-1];
        sum_s[PM]  <= sum_s[PM-1] + 35'(term_s[PM-1]);
        term_s[PM] <= 32'((64'(term_s[PM-1]) * 64'(r_s[PM-1]) + 64'h8000_0000) >> 32);
        r_s[PD]    <= r_s[PM];
        k_s[PD]    <= k_s[PM];
        sum_s[PD]  <= sum_s[PM];
        term_s[PD] <= 32'((65'(term_s[PM]) * 65'(MAGIC)) >> (32 + DL));
      end
    end
  end

  // scale back: (1 + sum) * 2^k - 1
  always_ff @(posedge clk) begin
    if (en) begin
      e <= EXP_W'((EXP_W'(35'(Q_ONE) + sum_s[NP]) << k_s[NP]) - EXP_W'(Q_ONE));
    end
  end

endmodule

`default_nettype wire

FILE: dv/pixel_log_exp_gamma_curve_check.sv
// Checker for the pixel tone curve: watches the pixel streams and config port,
// predicts each output pixel and compares. Depends on plg_pkg.
`default_nettype none

module pixel_log_exp_gamma_curve_check (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        cfg_we,
  input  logic [plg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [plg_pkg::CFG_DATA_W-1:0] cfg_data,
  output int          fail_count,
  output int          pending_pixels
);
  timeunit 1ns;
  timeprecision 1ps;
  import plg_pkg::*;

  localparam logic [63:0] PMAX  = 64'd65535;
  localparam logic [63:0] ONE   = 64'h1_0000_0000;
  localparam logic [63:0] HALF  = 64'h8000_0000;
  localparam logic [63:0] LN2   = 64'd2977044472;
  localparam logic [63:0] D_CAP = 64'h100_0000_0000;

  logic        inv_mode;
  logic [16:0] gamma_str;
  logic [15:0] pixel_q[$];

  // (a*b)/2^32, rounded to nearest
  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a >> 32) * b + (((a & 64'hFFFF_FFFF) * b + HALF) >> 32);
  endfunction

  // e^t - 1, all Q32
  function automatic logic [63:0] qexpm1(logic [63:0] t);
    logic [63:0] k, r, sum, term, i;
    k = t / LN2;
    r = t - k * LN2;
    sum = 0;
    term = r;
    i = 1;
    if (k > 30) k = 30;
    while (term != 0) begin
      sum += term;
      i++;
      term = qmul(term, r) / i;
    end
    return ((ONE + sum) << k) - ONE;
  endfunction

  // natural log, Q32, v >= 1
  function automatic logic [63:0] qln(logic [63:0] v);
    logic [63:0] k, m, u, u2, term, sum, n;
    k = 0;
    sum = 0;
    n = 1;
    if (v < ONE) return 0;
    while (k < 63 && (v >> k) >= 2 * ONE) k++;
    m = v >> k;
    u = ((m - ONE) << 32) / (m + ONE);
    u2 = qmul(u, u);
    term = u;
    while (term != 0) begin
      sum += term / n;
      term = qmul(term, u2);
      n += 2;
    end
    return k * LN2 + 2 * sum;
  endfunction

  function automatic logic [15:0] tone_map(logic [15:0] pix);
    logic [63:0] p, raw, a, t, d, n, xq, y, l, res;
    p = {48'd0, pix};
    raw = {47'd0, gamma_str};
    if (inv_mode) return pix ^ 16'hFFFF;
    if (raw == 0) return pix;
    if (raw[16]) begin
      // negative strength: scaled exponential
      a = 64'h20000 - raw;
      t = (((a * p) << 20) + PMAX / 2) / PMAX;
      d = qexpm1(a << 20);
      n = qexpm1(t);
      while (d >= D_CAP) begin
        d >>= 1;
        n >>= 1;
      end
      if (d == 0 || n >= d) return 16'hFFFF;
      res = (PMAX * n) / d;
    end else begin
      // positive strength: scaled logarithm
      xq = ((p << 32) + PMAX / 2) / PMAX;
      d = qexpm1(raw << 20);
      y = qmul(d, xq);
      l = qln(ONE + y);
      res = (PMAX * l) / (raw << 20);
    end
    return (res > PMAX) ? 16'hFFFF : res[15:0];
  endfunction

  always @(posedge clk) begin
    logic [15:0] want;
    if (rst) begin
      inv_mode <= 1'b0;
      gamma_str <= '0;
      fail_count <= 0;
      pending_pixels <= 0;
      pixel_q.delete();
    end else begin
      // requests use the settings in force before this edge
      if (s_axis_tvalid && s_axis_tready) pixel_q.push_back(tone_map(s_axis_tdata));
      if (cfg_we) begin
        if (cfg_index == REG_CURVE_MODE) inv_mode <= cfg_data[0];
        else if (cfg_index == REG_STRENGTH) gamma_str <= cfg_data;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected output pixel %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = pixel_q.pop_front();
          if (want !== m_axis_tdata) begin
            if (fail_count < 10)
              $display("pixel mismatch: expected %h got %h (mode %0d str %h)",
                       want, m_axis_tdata, inv_mode, gamma_str);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_pixels <= pixel_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: dv/pixel_log_exp_gamma_curve_test.sv
// Top of the tone curve testbench: clock, reset, stimulus and verdict.
// Depends on plg_pkg, pixel_log_exp_gamma_curve and its checker.
`default_nettype none

module pixel_log_exp_gamma_curve_test;
  timeunit 1ns;
  timeprecision 1ps;
  import plg_pkg::*;

  localparam int DRAIN = 400;
  localparam int WATCHDOG = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [15:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count, pending_pixels;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  pixel_log_exp_gamma_curve dut (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we, .cfg_index, .cfg_data
  );

  pixel_log_exp_gamma_curve_check checker_i (
    .clk, .rst, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending_pixels
  );

  // output backpressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic send_pixel(input logic [15:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = pix;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // settle the pipeline before touching config
  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_pixels != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // random pixels, biased toward the ends of the range now and then
  function automatic logic [15:0] pick_pixel();
    case ($urandom_range(7))
      0: return 16'($urandom_range(15));
      1: return 16'hFFFF - 16'($urandom_range(15));
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  initial begin
    logic [16:0] str_set[10];
    logic [15:0] edge_pix[8];
    str_set = '{17'h00000, 17'h10000, 17'h0FFFF, 17'h01000, 17'h1F000,
                17'h00001, 17'h1FFFF, 17'h08000, 17'h18000, 17'h00400};
    edge_pix = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000, 16'h7FFF,
                 16'hAAAA, 16'h5555};
    repeat (2) @(negedge clk);
    rst = 1'b0;

    // directed: edge pixels at extreme strengths and inversion
    for (int s = 0; s < 3; s++) begin
      write_reg(REG_STRENGTH, str_set[s]);
      foreach (edge_pix[i]) send_pixel(edge_pix[i]);
    end
    write_reg(REG_CURVE_MODE, CFG_DATA_W'(1));
    foreach (edge_pix[i]) send_pixel(edge_pix[i]);
    write_reg(REG_CURVE_MODE, CFG_DATA_W'(0));

    // random phases across strengths and idling patterns
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      write_reg(REG_CURVE_MODE, CFG_DATA_W'(ph % 5 == 4));
      write_reg(REG_STRENGTH, (ph < 10) ? str_set[ph] : 17'($urandom_range(17'h1FFFF)));
      for (int n = 0; n < 52; n++) begin
        // one mid-phase hold-off until the pipeline is empty
        if (ph == 6 && n == 26) begin
          s_axis_tvalid = 1'b0;
          while (pending_pixels != 0) @(negedge clk);
        end
        send_pixel(pick_pixel());
      end
    end

    wait_drained();
    if (fail_count == 0 && pending_pixels == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
